@@ rtl/ordered_list_with_positional_delete_macros.svh @@
// Assertion macros used by the checker of the ordered list block.
`ifndef ORDERED_LIST_WITH_POSITIONAL_DELETE_MACROS_SVH
`define ORDERED_LIST_WITH_POSITIONAL_DELETE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define OLPD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define OLPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/olpd_pkg.sv @@
// Types and constants of the ordered list with positional delete.
package olpd_pkg;

   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 3;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;
   // Wide enough for any list length up to 127.
   localparam int CNT_W    = 7;
   localparam int CMD_W    = 3;

   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DELETE     = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_DUMP       = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd3;

   localparam logic [CMD_W-1:0] CMD_HOLD       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ROTATE     = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] value;
      logic [CNT_W-1:0]         pos;
      logic [CNT_W-1:0]         count;
   } olpd_cell_ctl_type;

endpackage

@@ rtl/olpd_if.sv @@
// Request and response channel interfaces of the ordered list.
interface olpd_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [olpd_pkg::FUNC_W-1:0]          func;
   logic signed [olpd_pkg::DATA_W-1:0]   value;
   logic [olpd_pkg::POS_W-1:0]           position;

   modport source (output valid, func, value, position, input ready);
   modport sink (input valid, func, value, position, output ready);
endinterface

interface olpd_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [olpd_pkg::STATUS_W-1:0]        status;
   logic [olpd_pkg::COUNT_W-1:0]         count;
   logic signed [olpd_pkg::DATA_W-1:0]   element;
   logic                                 last;

   modport source (output valid, status, count, element, last, input ready);
   modport sink (input valid, status, count, element, last, output ready);
endinterface

@@ rtl/olpd_cell.sv @@
// One storage cell of the list chain; holds the element at a fixed position.
module olpd_cell #(
   parameter int INDEX = 0
) (
   input  logic                               clock,
   input  olpd_pkg::olpd_cell_ctl_type        ctl,
   input  logic signed [olpd_pkg::DATA_W-1:0] prev_value,
   input  logic signed [olpd_pkg::DATA_W-1:0] next_value,
   input  logic signed [olpd_pkg::DATA_W-1:0] wrap_value,
   output logic signed [olpd_pkg::DATA_W-1:0] value
);

   localparam logic [olpd_pkg::CNT_W-1:0] IDX = olpd_pkg::CNT_W'(INDEX);

   logic signed [olpd_pkg::DATA_W-1:0] value_ff;
   logic signed [olpd_pkg::DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      unique case (ctl.cmd)
         olpd_pkg::CMD_PUSH_FRONT: begin
            value_in = prev_value;
         end
         olpd_pkg::CMD_PUSH_BACK: begin
            if (IDX == ctl.count) begin
               value_in = ctl.value;
            end
         end
         olpd_pkg::CMD_REMOVE: begin
            if (IDX >= ctl.pos) begin
               value_in = next_value;
            end
         end
         olpd_pkg::CMD_ROTATE: begin
            // The front element goes to the tail of the occupied part.
            if (IDX + 1'b1 == ctl.count) begin
               value_in = wrap_value;
            end else begin
               value_in = next_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ rtl/ordered_list_with_positional_delete.sv @@
// Top level: ordered list of signed 32-bit values with positional delete.
// Push, pop, delete and unused codes: one item per cycle unless a result is stalled; the
// result is registered in the cycle after acceptance. A dump of a nonempty list yields one
// result per element; the cell chain rotates its front element to the tail for each result.
// Synchronous reset empties the list (count zero); cell contents are not cleared.
// No input item is taken while a result is stalled or a dump is in progress.
module ordered_list_with_positional_delete #(
   parameter int DEPTH = 32
) (
   input logic         clock,
   input logic         reset,
   olpd_req_if.sink    req_chan,
   olpd_rsp_if.source  rsp_chan
);

   localparam int CW = $clog2(DEPTH + 1);

   olpd_pkg::olpd_cell_ctl_type          ctl;
   logic signed [olpd_pkg::DATA_W-1:0]   cell_value [DEPTH];

   logic [CW-1:0]                        count_ff, count_in;
   logic [CW-1:0]                        dump_left_ff, dump_left_in;
   logic                                 dumping_ff, dumping_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [olpd_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [olpd_pkg::COUNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic signed [olpd_pkg::DATA_W-1:0]   rsp_element_ff, rsp_element_in;
   logic                                 rsp_last_ff, rsp_last_in;

   logic slot_free;
   logic accept;
   logic is_empty;
   logic is_full;
   logic load;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !dumping_ff && slot_free;
   assign accept = req_chan.valid && req_chan.ready;
   assign is_empty = (count_ff == '0);
   assign is_full = (count_ff == CW'(DEPTH));

   always_comb begin
      ctl.cmd        = olpd_pkg::CMD_HOLD;
      ctl.value      = req_chan.value;
      ctl.pos        = olpd_pkg::CNT_W'(req_chan.position);
      ctl.count      = olpd_pkg::CNT_W'(count_ff);
      count_in       = count_ff;
      dump_left_in   = dump_left_ff;
      dumping_in     = dumping_ff;
      load           = 1'b0;
      rsp_status_in  = olpd_pkg::STATUS_OK;
      rsp_element_in = '0;
      rsp_last_in    = 1'b1;

      if (dumping_ff) begin
         if (slot_free) begin
            ctl.cmd        = olpd_pkg::CMD_ROTATE;
            load           = 1'b1;
            rsp_element_in = cell_value[0];
            rsp_last_in    = (dump_left_ff == CW'(1));
            dump_left_in   = dump_left_ff - 1'b1;
            dumping_in     = (dump_left_ff != CW'(1));
         end
      end else if (accept) begin
         load = 1'b1;
         unique case (req_chan.func)
            olpd_pkg::FUNC_PUSH_FRONT: begin
               if (is_full) begin
                  rsp_status_in = olpd_pkg::STATUS_FULL;
               end else begin
                  ctl.cmd  = olpd_pkg::CMD_PUSH_FRONT;
                  count_in = count_ff + 1'b1;
               end
            end
            olpd_pkg::FUNC_PUSH_BACK: begin
               if (is_full) begin
                  rsp_status_in = olpd_pkg::STATUS_FULL;
               end else begin
                  ctl.cmd  = olpd_pkg::CMD_PUSH_BACK;
                  count_in = count_ff + 1'b1;
               end
            end
            olpd_pkg::FUNC_POP_FRONT: begin
               if (is_empty) begin
                  rsp_status_in = olpd_pkg::STATUS_EMPTY;
               end else begin
                  ctl.cmd  = olpd_pkg::CMD_REMOVE;
                  ctl.pos  = '0;
                  count_in = count_ff - 1'b1;
               end
            end
            olpd_pkg::FUNC_POP_BACK: begin
               if (is_empty) begin
                  rsp_status_in = olpd_pkg::STATUS_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            olpd_pkg::FUNC_DELETE: begin
               if (is_empty) begin
                  rsp_status_in = olpd_pkg::STATUS_EMPTY;
               end else if (olpd_pkg::CNT_W'(req_chan.position)
                            >= olpd_pkg::CNT_W'(count_ff)) begin
                  rsp_status_in = olpd_pkg::STATUS_BADPOS;
               end else begin
                  ctl.cmd  = olpd_pkg::CMD_REMOVE;
                  count_in = count_ff - 1'b1;
               end
            end
            olpd_pkg::FUNC_DUMP: begin
               if (is_empty) begin
                  rsp_status_in = olpd_pkg::STATUS_EMPTY;
               end else begin
                  // The first element leaves in the accepting cycle.
                  ctl.cmd        = olpd_pkg::CMD_ROTATE;
                  rsp_element_in = cell_value[0];
                  rsp_last_in    = (count_ff == CW'(1));
                  dump_left_in   = count_ff - 1'b1;
                  dumping_in     = (count_ff != CW'(1));
               end
            end
            default: begin
               rsp_status_in = olpd_pkg::STATUS_OK;
            end
         endcase
      end

      rsp_count_in = olpd_pkg::COUNT_W'(count_in);
      rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [olpd_pkg::DATA_W-1:0] prev_value;
      logic signed [olpd_pkg::DATA_W-1:0] next_value;

      if (i == 0) begin : g_first
         assign prev_value = ctl.value;
      end else begin : g_mid
         assign prev_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_value = cell_value[i];
      end else begin : g_body
         assign next_value = cell_value[i+1];
      end

      olpd_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .prev_value (prev_value),
         .next_value (next_value),
         .wrap_value (cell_value[0]),
         .value      (cell_value[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dump_left_ff <= '0;
         dumping_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         dumping_ff   <= dumping_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_element_ff <= rsp_element_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.status  = rsp_status_ff;
   assign rsp_chan.count   = rsp_count_ff;
   assign rsp_chan.element = rsp_element_ff;
   assign rsp_chan.last    = rsp_last_ff;

endmodule

@@ rtl/olpd_checker.sv @@
// Port-level checker for the ordered list, bound to the top level.
`include "ordered_list_with_positional_delete_macros.svh"

module olpd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [olpd_pkg::STATUS_W-1:0]      rsp_status,
   input logic [olpd_pkg::COUNT_W-1:0]       rsp_count,
   input logic signed [olpd_pkg::DATA_W-1:0] rsp_element,
   input logic                               rsp_last
);

   `OLPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_count) && $stable(rsp_element) && $stable(rsp_last),
      "stalled result item changed")

   `OLPD_ASSERT_SAME(a_no_accept_on_stall, clock, reset, req_valid && req_ready,
      !(rsp_valid && !rsp_ready), "item accepted while a result item is stalled")

   `OLPD_ASSERT_SAME(a_error_is_single, clock, reset,
      rsp_valid && (rsp_status != olpd_pkg::STATUS_OK),
      rsp_last && (rsp_element == '0), "error result item is not a lone zero item")

   `OLPD_ASSERT_SAME(a_empty_count, clock, reset,
      rsp_valid && (rsp_status == olpd_pkg::STATUS_EMPTY),
      rsp_count == '0, "empty status with nonzero count")

endmodule

bind ordered_list_with_positional_delete olpd_checker u_olpd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_status  (rsp_chan.status),
   .rsp_count   (rsp_chan.count),
   .rsp_element (rsp_chan.element),
   .rsp_last    (rsp_chan.last)
);

@@ tb/tb_ordered_list_with_positional_delete.sv @@
// Testbench for the ordered list with positional delete: directed and random traffic checked against a predictor.
module tb_ordered_list_with_positional_delete;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH   = 32;
   localparam int RANDOM_ITEMS = 138;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 40;

   // Codes the block accepts but does nothing with.
   localparam logic [olpd_pkg::FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
   localparam logic [olpd_pkg::FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

   localparam logic signed [olpd_pkg::DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [olpd_pkg::DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic [olpd_pkg::STATUS_W-1:0]      status;
      logic [olpd_pkg::COUNT_W-1:0]       count;
      logic signed [olpd_pkg::DATA_W-1:0] element;
      logic                               last;
   } list_response_type;

   class ordered_list_tracker_type;
      int                                 depth;
      int                                 mismatch_count;
      logic signed [olpd_pkg::DATA_W-1:0] list_contents[$];
      list_response_type                  expected_responses[$];

      function new(int list_depth);
         depth = list_depth;
         mismatch_count = 0;
      endfunction

      function int occupancy();
         return list_contents.size();
      endfunction

      function int outstanding();
         return expected_responses.size();
      endfunction

      function void report(string what);
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("%s", what);
         end
      endfunction

      function void expect_response(logic [olpd_pkg::STATUS_W-1:0] st,
                                    logic signed [olpd_pkg::DATA_W-1:0] elem,
                                    logic lst);
         list_response_type r;
         r.status  = st;
         r.count   = olpd_pkg::COUNT_W'(list_contents.size());
         r.element = elem;
         r.last    = lst;
         expected_responses.push_back(r);
      endfunction

      // Updates the list for one accepted item and queues the responses it causes.
      function void apply_command(logic [olpd_pkg::FUNC_W-1:0] f,
                                  logic signed [olpd_pkg::DATA_W-1:0] v,
                                  logic [olpd_pkg::POS_W-1:0] p);
         int n;
         logic [olpd_pkg::STATUS_W-1:0] st;
         n  = list_contents.size();
         st = olpd_pkg::STATUS_OK;
         case (f)
            olpd_pkg::FUNC_PUSH_FRONT: begin
               if (n >= depth) st = olpd_pkg::STATUS_FULL;
               else list_contents.push_front(v);
            end
            olpd_pkg::FUNC_PUSH_BACK: begin
               if (n >= depth) st = olpd_pkg::STATUS_FULL;
               else list_contents.push_back(v);
            end
            olpd_pkg::FUNC_POP_FRONT: begin
               if (n == 0) st = olpd_pkg::STATUS_EMPTY;
               else void'(list_contents.pop_front());
            end
            olpd_pkg::FUNC_POP_BACK: begin
               if (n == 0) st = olpd_pkg::STATUS_EMPTY;
               else void'(list_contents.pop_back());
            end
            olpd_pkg::FUNC_DELETE: begin
               if (n == 0) st = olpd_pkg::STATUS_EMPTY;
               else if (int'(p) >= n) st = olpd_pkg::STATUS_BADPOS;
               else list_contents.delete(int'(p));
            end
            olpd_pkg::FUNC_DUMP: begin
               if (n == 0) begin
                  expect_response(olpd_pkg::STATUS_EMPTY, '0, 1'b1);
               end else begin
                  for (int i = 0; i < n; i++) begin
                     expect_response(olpd_pkg::STATUS_OK, list_contents[i], i == n - 1);
                  end
               end
               return;
            end
            default: ;
         endcase
         expect_response(st, '0, 1'b1);
      endfunction

      function void compare_response(logic [olpd_pkg::STATUS_W-1:0] st,
                                     logic [olpd_pkg::COUNT_W-1:0] cnt,
                                     logic signed [olpd_pkg::DATA_W-1:0] elem, logic lst);
         list_response_type want;
         if (expected_responses.size() == 0) begin
            report($sformatf("unexpected response: status %0d count %0d element %0d last %0b",
                             st, cnt, elem, lst));
            return;
         end
         want = expected_responses.pop_front();
         if (want.status !== st || want.count !== cnt || want.element !== elem ||
             want.last !== lst) begin
            report($sformatf({"response mismatch: expected status %0d count %0d element %0d",
                              " last %0b, got status %0d count %0d element %0d last %0b"},
                             want.status, want.count, want.element, want.last,
                             st, cnt, elem, lst));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm  = 1'b0;
   int   rsp_hold = 0;

   ordered_list_tracker_type tracker = new(LIST_DEPTH);

   olpd_req_if req_if();
   olpd_rsp_if rsp_if();

   ordered_list_with_positional_delete #(
      .DEPTH(LIST_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      req_if.valid    = 1'b0;
      req_if.func     = olpd_pkg::FUNC_PUSH_BACK;
      req_if.value    = '0;
      req_if.position = '0;
      rsp_if.ready    = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic signed [olpd_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return '0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   // Switches at random between stretches with stalls on both sides and stretches without any.
   initial begin
      forever begin
         repeat ($urandom_range(100, 400)) @(posedge clock);
         calm <= ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!calm && $urandom_range(0, 2) == 0) rsp_hold <= gap_length();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         tracker.compare_response(rsp_if.status, rsp_if.count, rsp_if.element, rsp_if.last);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   task automatic send_command(logic [olpd_pkg::FUNC_W-1:0] f,
                               logic signed [olpd_pkg::DATA_W-1:0] v,
                               logic [olpd_pkg::POS_W-1:0] p);
      int gap;
      gap = (calm || $urandom_range(0, 1) == 0) ? 0 : gap_length();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.func     <= f;
      req_if.value    <= v;
      req_if.position <= p;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tracker.apply_command(f, v, p);
   endtask

   task automatic run_random(int items);
      logic filling;
      int n;
      int r;
      logic [olpd_pkg::FUNC_W-1:0] f;
      logic [olpd_pkg::POS_W-1:0] p;
      filling = 1'b1;
      for (int k = 0; k < items; k++) begin
         n = tracker.occupancy();
         if (n >= LIST_DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
         if (n == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
         if ($urandom_range(0, 39) == 0) filling = !filling;
         r = $urandom_range(0, 99);
         if (filling) begin
            if (r < 65) f = $urandom_range(0, 1) ? olpd_pkg::FUNC_PUSH_FRONT
                                                 : olpd_pkg::FUNC_PUSH_BACK;
            else if (r < 75) f = olpd_pkg::FUNC_DELETE;
            else if (r < 82) f = $urandom_range(0, 1) ? olpd_pkg::FUNC_POP_FRONT
                                                      : olpd_pkg::FUNC_POP_BACK;
            else if (r < 93) f = olpd_pkg::FUNC_DUMP;
            else f = $urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B;
         end else begin
            if (r < 25) f = olpd_pkg::FUNC_POP_FRONT;
            else if (r < 50) f = olpd_pkg::FUNC_POP_BACK;
            else if (r < 75) f = olpd_pkg::FUNC_DELETE;
            else if (r < 85) f = $urandom_range(0, 1) ? olpd_pkg::FUNC_PUSH_FRONT
                                                      : olpd_pkg::FUNC_PUSH_BACK;
            else if (r < 96) f = olpd_pkg::FUNC_DUMP;
            else f = $urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B;
         end
         // Deletes mostly hit a live element; the rest may land past the end.
         if (f == olpd_pkg::FUNC_DELETE && n > 0 && $urandom_range(0, 4) != 0) begin
            p = olpd_pkg::POS_W'($urandom_range(0, n - 1));
         end else begin
            p = olpd_pkg::POS_W'($urandom_range(0, 31));
         end
         send_command(f, pick_value(), p);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Operations on an empty list and the unused codes, then pushes at both ends and a dump.
      send_command(olpd_pkg::FUNC_DUMP, 32'sd5, 5'd0);
      send_command(olpd_pkg::FUNC_POP_FRONT, 32'sd0, 5'd0);
      send_command(olpd_pkg::FUNC_POP_BACK, 32'sd0, 5'd0);
      send_command(olpd_pkg::FUNC_DELETE, 32'sd0, 5'd0);
      send_command(olpd_pkg::FUNC_DELETE, 32'sd0, 5'd31);
      send_command(FUNC_SPARE_A, VALUE_MAX, 5'd31);
      send_command(olpd_pkg::FUNC_PUSH_BACK, VALUE_MAX, 5'd0);
      send_command(olpd_pkg::FUNC_PUSH_FRONT, VALUE_MIN, 5'd31);
      send_command(olpd_pkg::FUNC_PUSH_BACK, 32'sd0, 5'd0);
      send_command(olpd_pkg::FUNC_PUSH_FRONT, -32'sd1, 5'd0);
      send_command(FUNC_SPARE_B, VALUE_MIN, 5'd0);
      send_command(olpd_pkg::FUNC_DUMP, 32'sd0, 5'd0);
      // Positions at and past the count, then deletes in the middle and at the tail.
      send_command(olpd_pkg::FUNC_DELETE, 32'sd0, 5'd4);
      send_command(olpd_pkg::FUNC_DELETE, 32'sd0, 5'd31);
      send_command(olpd_pkg::FUNC_DELETE, 32'sd0, 5'd1);
      send_command(olpd_pkg::FUNC_DELETE, 32'sd0, 5'd2);
      send_command(olpd_pkg::FUNC_DUMP, 32'sd0, 5'd0);
      send_command(olpd_pkg::FUNC_POP_FRONT, 32'sd0, 5'd0);
      send_command(olpd_pkg::FUNC_POP_BACK, 32'sd0, 5'd0);
      send_command(olpd_pkg::FUNC_POP_BACK, 32'sd0, 5'd0);
      send_command(olpd_pkg::FUNC_PUSH_FRONT, 32'sh5a5a_5a5a, 5'd21);
      send_command(olpd_pkg::FUNC_DELETE, 32'sd0, 5'd0);

      run_random(RANDOM_ITEMS);
      req_if.valid <= 1'b0;

      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.mismatch_count == 0 && tracker.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/olpd_pkg.sv
rtl/olpd_if.sv
rtl/olpd_cell.sv
rtl/ordered_list_with_positional_delete.sv
rtl/olpd_checker.sv
tb/tb_ordered_list_with_positional_delete.sv
